>>> rtl/pimd_pkg.sv
// pimd_pkg: shared types and constants of the pulse interval mode decoder
// item structs, event codes, register indexes and register file layout
// no dependencies
package pimd_pkg;

   typedef struct packed {
      logic        req_type;   // 0 falling edge, 1 poll
      logic [31:0] now_ms;
   } req_item_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_ENTER   = 2'd1,
      EV_EXIT    = 2'd2,
      EV_EXPIRED = 2'd3
   } event_type;

   typedef struct packed {
      event_type event_res;
      logic      service_mode;
   } rsp_item_type;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 31;

   localparam logic [CsrIndexWidth-1:0] CSR_BREAK_MIN     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_MIN     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_MAX     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DELIMITER_MIN = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DELIMITER_MAX = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_TRAILER_MIN   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_SYNC_TIMEOUT  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_LEASE         = 3'd7;

   typedef struct packed {
      logic [15:0] break_min_ms;
      logic [15:0] short_min_ms;
      logic [15:0] short_max_ms;
      logic [15:0] delimiter_min_ms;
      logic [15:0] delimiter_max_ms;
      logic [15:0] trailer_min_ms;
      logic [15:0] sync_timeout_ms;
      logic [30:0] lease_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      break_min_ms:     16'd200,
      short_min_ms:     16'd20,
      short_max_ms:     16'd80,
      delimiter_min_ms: 16'd100,
      delimiter_max_ms: 16'd180,
      trailer_min_ms:   16'd200,
      sync_timeout_ms:  16'd500,
      lease_ms:         31'd60000
   };

   localparam logic [2:0] PULSES_ENTER = 3'd3;
   localparam logic [2:0] PULSES_EXIT  = 3'd4;

endpackage

>>> rtl/pimd_csr.sv
// pimd_csr: configuration register file of the mode decoder
// depends on pimd_pkg for the register layout and indexes
module pimd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [pimd_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [pimd_pkg::CsrDataWidth-1:0]      csr_wdata,
   output pimd_pkg::cfg_type                      cfg
);

   pimd_pkg::cfg_type cfg_ff;
   pimd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pimd_pkg::CSR_BREAK_MIN:     cfg_in.break_min_ms     = csr_wdata[15:0];
            pimd_pkg::CSR_SHORT_MIN:     cfg_in.short_min_ms     = csr_wdata[15:0];
            pimd_pkg::CSR_SHORT_MAX:     cfg_in.short_max_ms     = csr_wdata[15:0];
            pimd_pkg::CSR_DELIMITER_MIN: cfg_in.delimiter_min_ms = csr_wdata[15:0];
            pimd_pkg::CSR_DELIMITER_MAX: cfg_in.delimiter_max_ms = csr_wdata[15:0];
            pimd_pkg::CSR_TRAILER_MIN:   cfg_in.trailer_min_ms   = csr_wdata[15:0];
            pimd_pkg::CSR_SYNC_TIMEOUT:  cfg_in.sync_timeout_ms  = csr_wdata[15:0];
            pimd_pkg::CSR_LEASE:         cfg_in.lease_ms         = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pimd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/pimd_core.sv
// pimd_core: decoder state and the per-item step logic
// depends on pimd_pkg for item structs, event codes and register layout
module pimd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  pimd_pkg::req_item_type  item,
   input  pimd_pkg::cfg_type       cfg,
   output pimd_pkg::rsp_item_type  result
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SYNC    = 2'd1,
      PH_DELIM   = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   logic        have_edge_ff,      have_edge_in;
   phase_type   phase_ff,          phase_in;
   logic [2:0]  pulse_count_ff,    pulse_count_in;
   logic        active_ff,         active_in;
   logic        pending_ff,        pending_in;
   logic [31:0] last_edge_ff,      last_edge_in;
   logic [31:0] deadline_ff,       deadline_in;

   logic [31:0]         interval;
   logic [31:0]         since_deadline;
   logic [31:0]         new_deadline;
   logic                is_short;
   pimd_pkg::event_type ev;

   assign interval       = item.now_ms - last_edge_ff;
   assign since_deadline = item.now_ms - deadline_ff;
   assign new_deadline   = item.now_ms + {1'b0, cfg.lease_ms};
   assign is_short       = (interval >= 32'(cfg.short_min_ms)) &&
                           (interval <= 32'(cfg.short_max_ms));

   always_comb begin
      have_edge_in   = have_edge_ff;
      phase_in       = phase_ff;
      pulse_count_in = pulse_count_ff;
      active_in      = active_ff;
      pending_in     = pending_ff;
      last_edge_in   = last_edge_ff;
      deadline_in    = deadline_ff;
      ev             = pimd_pkg::EV_NONE;
      if (step) begin
         if (!item.req_type) begin
            last_edge_in = item.now_ms;
            if (!have_edge_ff) begin
               have_edge_in = 1'b1;
            end else begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (interval >= 32'(cfg.break_min_ms)) phase_in = PH_SYNC;
                  end
                  PH_SYNC: begin
                     if (is_short) begin
                        phase_in = PH_DELIM;
                     end else begin
                        phase_in       = PH_IDLE;
                        pulse_count_in = '0;
                     end
                  end
                  PH_DELIM: begin
                     phase_in       = PH_IDLE;
                     pulse_count_in = '0;
                     if (interval >= 32'(cfg.delimiter_min_ms) &&
                         interval <= 32'(cfg.delimiter_max_ms)) begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     if (interval >= 32'(cfg.trailer_min_ms)) begin
                        // trailer closes the frame, event reported by next poll
                        if (pulse_count_ff == pimd_pkg::PULSES_ENTER) begin
                           active_in  = 1'b1;
                           pending_in = 1'b1;
                        end else if (pulse_count_ff == pimd_pkg::PULSES_EXIT) begin
                           active_in   = 1'b0;
                           pending_in  = 1'b1;
                           deadline_in = '0;
                        end
                        phase_in       = PH_IDLE;
                        pulse_count_in = '0;
                     end else if (!is_short || pulse_count_ff >= pimd_pkg::PULSES_EXIT) begin
                        phase_in       = PH_IDLE;
                        pulse_count_in = '0;
                     end else begin
                        pulse_count_in = pulse_count_ff + 3'd1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end else begin
            if (pending_ff) begin
               pending_in = 1'b0;
               if (active_ff) begin
                  deadline_in = new_deadline;
                  ev          = pimd_pkg::EV_ENTER;
               end else begin
                  ev = pimd_pkg::EV_EXIT;
               end
            end else if (active_ff && !since_deadline[31]) begin
               // wrap-safe: deadline reached within the last half range
               active_in   = 1'b0;
               deadline_in = '0;
               ev          = pimd_pkg::EV_EXPIRED;
            end else if (have_edge_ff) begin
               if (phase_ff == PH_PAYLOAD) begin
                  if (interval >= 32'(cfg.trailer_min_ms)) begin
                     phase_in       = PH_IDLE;
                     pulse_count_in = '0;
                     if (pulse_count_ff == pimd_pkg::PULSES_ENTER) begin
                        active_in   = 1'b1;
                        deadline_in = new_deadline;
                        ev          = pimd_pkg::EV_ENTER;
                     end else if (pulse_count_ff == pimd_pkg::PULSES_EXIT) begin
                        if (active_ff) begin
                           active_in   = 1'b0;
                           deadline_in = '0;
                        end
                        ev = pimd_pkg::EV_EXIT;
                     end
                  end
               end else if (phase_ff != PH_IDLE) begin
                  if (interval >= 32'(cfg.sync_timeout_ms)) begin
                     phase_in       = PH_IDLE;
                     pulse_count_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_edge_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         pulse_count_ff <= '0;
         active_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         last_edge_ff   <= '0;
         deadline_ff    <= '0;
      end else begin
         have_edge_ff   <= have_edge_in;
         phase_ff       <= phase_in;
         pulse_count_ff <= pulse_count_in;
         active_ff      <= active_in;
         pending_ff     <= pending_in;
         last_edge_ff   <= last_edge_in;
         deadline_ff    <= deadline_in;
      end
   end

   assign result.event_res    = ev;
   assign result.service_mode = active_in;

endmodule

>>> rtl/pulse_interval_mode_decoder.sv
// pulse_interval_mode_decoder: an accepted item waits in the input register,
// then step logic loads its result into the result register, raising rsp_valid
// throughput one item per cycle while rsp_ready holds; the single step stage sets the rate
// req_ready stays high while the result register drains or is free
// synchronous active-high reset clears core state and handshakes, presets CSRs
module pulse_interval_mode_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pimd_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pimd_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [pimd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pimd_pkg::CsrDataWidth-1:0]   csr_wdata
);

   pimd_pkg::cfg_type      cfg;
   pimd_pkg::rsp_item_type step_result;

   logic                   in_valid_ff, in_valid_in;
   pimd_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   pimd_pkg::rsp_item_type out_item_ff;
   logic                   advance;
   logic                   req_take;

   // an item moves into the result register when that register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   pimd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pimd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) in_item_ff <= req_data;
      if (advance)  out_item_ff <= step_result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

`ifndef SYNTHESIS
   a_enter_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == pimd_pkg::EV_ENTER |-> rsp_data.service_mode)
      else $error("enter reported without maintenance mode");

   a_leave_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == pimd_pkg::EV_EXIT ||
                    rsp_data.event_res == pimd_pkg::EV_EXPIRED)
      |-> !rsp_data.service_mode)
      else $error("exit or expiry reported while still in maintenance mode");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && out_valid_ff)
      else $error("item lost while result register stalled");
`endif

endmodule
